// File: hdl/swr_pkg.sv
// package for the sliding window receiver: widths, defaults and the
// command / status structs between controller and datapath
// no dependencies
package swr_pkg;

    localparam int unsigned SENDERS_DEF = 16;
    localparam int unsigned WINDOW_DEF  = 8;

    localparam int unsigned SENDER_W  = 4;
    localparam int unsigned SEQ_W     = 8;
    localparam int unsigned PAY_W     = 64;
    localparam int unsigned ID_W      = 8;
    localparam int unsigned WCFG_W    = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned MODCNT_W  = 3;

    localparam logic [WCFG_W-1:0] WINDOW_RESET = WCFG_W'(8);
    localparam logic [ID_W-1:0]   OWN_ID_RESET = '0;
    localparam logic [SEQ_W-1:0]  LR_RESET     = '1;
    // largest acceptable always sits this far past last received
    localparam logic [SEQ_W-1:0]  LA_OFFSET    = SEQ_W'(WINDOW_RESET);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = CFG_IDX_W'(1);

    localparam logic KIND_DELIVERY = 1'b0;
    localparam logic KIND_ACK      = 1'b1;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic store;
        logic rd;
        logic deliver;
        logic out_ack;
    } t_cmd;

    typedef struct packed {
        logic good;
        logic mod_done;
        logic in_win;
        logic is_next;
        logic slot_recv;
        logic slot_end;
        logic iter_last;
    } t_status;

endpackage

// File: hdl/swr_ram.sv
// generic single-port ram with registered read
// no dependencies
module swr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/swr_ctrl.sv
// controller state machine of the sliding window receiver
// depends on swr_pkg
module swr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  swr_pkg::t_status i_status,
    output swr_pkg::t_cmd    o_cmd
);
    import swr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_STORE = 6'b000100,
        S_CHECK = 6'b001000,
        S_DLV   = 6'b010000,
        S_ACK   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_status.good) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = (i_status.in_win && i_status.is_next) ? S_CHECK : S_ACK;
            end
            S_CHECK: begin
                o_cmd.rd = 1'b1;
                n_state = i_status.slot_recv ? S_DLV : S_ACK;
            end
            S_DLV: begin
                o_valid       = 1'b1;
                o_cmd.deliver = i_ready;
                if (i_ready) begin
                    n_state = (i_status.slot_end || i_status.iter_last) ? S_ACK : S_CHECK;
                end
            end
            S_ACK: begin
                o_valid       = 1'b1;
                o_cmd.out_ack = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_bad_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && !i_status.good) |=> (r_state == S_IDLE))
        else $error("bad frame not dropped");
    a_end_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLV && i_ready && i_status.slot_end) |=> (r_state == S_ACK))
        else $error("end of message did not stop drain");
    a_mod_before_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> $past(r_state == S_MOD && i_status.mod_done))
        else $error("store without finished slot index");
`endif
endmodule

// File: hdl/swr_datapath.sv
// datapath of the sliding window receiver: per-sender window state, slot
// flags, payload ram, slot index remainder unit and result fields
// depends on swr_pkg and swr_ram
module swr_datapath #(
    parameter int unsigned SENDERS = swr_pkg::SENDERS_DEF,
    parameter int unsigned WINDOW  = swr_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swr_pkg::ID_W-1:0]      i_cfg_data,
    input  logic [swr_pkg::SENDER_W-1:0]  i_sender,
    input  logic [swr_pkg::SEQ_W-1:0]     i_seq,
    input  logic                          i_crc_good,
    input  logic                          i_final_frame,
    input  logic [swr_pkg::PAY_W-1:0]     i_payload_handle,
    input  swr_pkg::t_cmd                 i_cmd,
    output swr_pkg::t_status              o_status,
    output logic                          o_kind,
    output logic [swr_pkg::SENDER_W-1:0]  o_peer,
    output logic [swr_pkg::ID_W-1:0]      o_from_id,
    output logic [swr_pkg::SEQ_W-1:0]     o_seq_out,
    output logic [swr_pkg::PAY_W-1:0]     o_payload_out,
    output logic                          o_message_end,
    output logic                          o_last
);
    import swr_pkg::*;

    localparam int unsigned SRC_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned REM_W  = SLOT_W + 1;
    localparam int unsigned WW     = $clog2(WINDOW + 1);
    localparam int unsigned ROWS   = 1 << SLOT_W;
    localparam int unsigned DEPTH  = (1 << SRC_W) * ROWS;

    logic [WCFG_W-1:0]   r_window_size;
    logic [ID_W-1:0]     r_own_id;
    logic [SEQ_W-1:0]    r_lr [SENDERS];
    logic [WINDOW-1:0]   r_recv [SENDERS];
    logic [WINDOW-1:0]   r_fin  [SENDERS];

    logic [SRC_W-1:0]    r_src;
    logic [SEQ_W-1:0]    r_seq;
    logic                r_fin_in;
    logic [PAY_W-1:0]    r_pay;
    logic [MODCNT_W-1:0] r_mcnt;
    logic [REM_W-1:0]    r_rem;
    logic [SLOT_W-1:0]   r_idx;
    logic [WW-1:0]       r_iter;

    logic [SRC_W-1:0]    src_in;
    logic [WW-1:0]       w_eff;
    logic [REM_W-1:0]    rem_sh, rem_nx;
    logic [SLOT_W-1:0]   slot;
    logic [SEQ_W-1:0]    lr_cur, lr_inc, d_lr, d_la;
    logic [SLOT_W-1:0]   idx_inc;
    logic                ram_we;
    logic [$clog2(DEPTH)-1:0] ram_addr;
    logic [PAY_W-1:0]    ram_q;

    // sender id folded onto the sender table
    always_comb begin
        src_in = '0;
        for (int k = 0; k < (1 << SENDER_W); k++) begin
            if (i_sender == SENDER_W'(k)) begin
                src_in = SRC_W'(k % SENDERS);
            end
        end
    end

    always_comb begin
        if (r_window_size == '0) begin
            w_eff = WW'(1);
        end else if (r_window_size > WCFG_W'(WINDOW)) begin
            w_eff = WW'(WINDOW);
        end else begin
            w_eff = WW'(r_window_size);
        end
    end

    // restoring remainder seq mod window, one bit per cycle from the msb
    always_comb begin
        rem_sh = {r_rem[REM_W-2:0], r_seq[SEQ_W-1-r_mcnt]};
        rem_nx = (rem_sh >= REM_W'(w_eff)) ? rem_sh - REM_W'(w_eff) : rem_sh;
    end
    assign slot = SLOT_W'(r_rem);

    assign lr_cur  = r_lr[r_src];
    assign lr_inc  = lr_cur + SEQ_W'(1);
    assign d_lr    = lr_cur - r_seq;
    assign d_la    = (lr_cur + LA_OFFSET) - r_seq;
    // sequence wraps from 255 to 0, which always lands in slot 0
    assign idx_inc = ((WW'(r_idx) + WW'(1) == w_eff) || (lr_inc == '1)) ? '0 :
                     r_idx + SLOT_W'(1);

    assign o_status.good      = i_crc_good;
    assign o_status.mod_done  = (r_mcnt == MODCNT_W'(SEQ_W - 1));
    assign o_status.in_win    = d_lr[SEQ_W-1] && !d_la[SEQ_W-1];
    assign o_status.is_next   = (r_seq == lr_inc);
    assign o_status.slot_recv = r_recv[r_src][r_idx];
    assign o_status.slot_end  = r_fin[r_src][r_idx];
    assign o_status.iter_last = (r_iter + WW'(1) == w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RESET;
            r_own_id      <= OWN_ID_RESET;
            for (int s = 0; s < SENDERS; s++) begin
                r_lr[s]   <= LR_RESET;
                r_recv[s] <= '0;
                r_fin[s]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW_SIZE: r_window_size <= i_cfg_data[WCFG_W-1:0];
                    REG_OWN_ID:      r_own_id <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store && o_status.in_win) begin
                r_recv[r_src][slot] <= 1'b1;
                r_fin[r_src][slot]  <= r_fin_in;
            end
            if (i_cmd.deliver) begin
                r_lr[r_src] <= lr_inc;
                if (r_fin[r_src][r_idx]) begin
                    r_recv[r_src] <= '0;
                    r_fin[r_src]  <= '0;
                end else begin
                    r_recv[r_src][r_idx] <= 1'b0;
                    r_fin[r_src][r_idx]  <= 1'b0;
                end
            end
        end
    end

    // item and drain registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src    <= src_in;
            r_seq    <= i_seq;
            r_fin_in <= i_final_frame;
            r_pay    <= i_payload_handle;
            r_mcnt   <= '0;
            r_rem    <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem  <= rem_nx;
            r_mcnt <= r_mcnt + MODCNT_W'(1);
        end
        if (i_cmd.store) begin
            r_idx  <= slot;
            r_iter <= '0;
        end
        if (i_cmd.deliver) begin
            r_idx  <= idx_inc;
            r_iter <= r_iter + WW'(1);
        end
    end

    assign ram_we   = i_cmd.store && o_status.in_win;
    assign ram_addr = {r_src, (i_cmd.store ? slot : r_idx)};

    swr_ram #(
        .WIDTH(PAY_W),
        .DEPTH(DEPTH)
    ) u_pay_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (i_cmd.rd),
        .i_addr (ram_addr),
        .i_wdata(r_pay),
        .o_rdata(ram_q)
    );

    // delivery and ack both carry last received plus one
    assign o_kind        = i_cmd.out_ack ? KIND_ACK : KIND_DELIVERY;
    assign o_peer        = SENDER_W'(r_src);
    assign o_from_id     = i_cmd.out_ack ? r_own_id : '0;
    assign o_seq_out     = lr_inc;
    assign o_payload_out = i_cmd.out_ack ? r_pay : ram_q;
    assign o_message_end = i_cmd.out_ack ? 1'b0 : r_fin[r_src][r_idx];
    assign o_last        = i_cmd.out_ack;
endmodule

// File: hdl/sliding_window_receiver_core.sv
// selective repeat receiver: one frame at a time, deliveries then one ack
// steps: accept, slot index, store, then for each delivered frame a slot
// check with ram read and a beat out, a last check when the drain stops on
// an empty slot, and the ack beat; output stalls hold the delivery and ack
// beats. a new frame is taken only in idle, so not before the ack of the last
// good frame has gone out; a bad frame is dropped at accept
// reset: synchronous active low, clears window state and slot flags at once
// depends on swr_pkg, swr_ctrl, swr_datapath, swr_ram
module sliding_window_receiver_core #(
    parameter int unsigned SENDERS = swr_pkg::SENDERS_DEF,
    parameter int unsigned WINDOW  = swr_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swr_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [swr_pkg::SENDER_W-1:0]  i_sender,
    input  logic [swr_pkg::SEQ_W-1:0]     i_seq,
    input  logic                          i_crc_good,
    input  logic                          i_final_frame,
    input  logic [swr_pkg::PAY_W-1:0]     i_payload_handle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [swr_pkg::SENDER_W-1:0]  o_peer,
    output logic [swr_pkg::ID_W-1:0]      o_from_id,
    output logic [swr_pkg::SEQ_W-1:0]     o_seq_out,
    output logic [swr_pkg::PAY_W-1:0]     o_payload_out,
    output logic                          o_message_end,
    output logic                          o_last
);
    import swr_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    swr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_status(status),
        .o_cmd   (cmd)
    );

    swr_datapath #(
        .SENDERS(SENDERS),
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sender        (i_sender),
        .i_seq           (i_seq),
        .i_crc_good      (i_crc_good),
        .i_final_frame   (i_final_frame),
        .i_payload_handle(i_payload_handle),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_kind          (o_kind),
        .o_peer          (o_peer),
        .o_from_id       (o_from_id),
        .o_seq_out       (o_seq_out),
        .o_payload_out   (o_payload_out),
        .o_message_end   (o_message_end),
        .o_last          (o_last)
    );
endmodule
